>>> rtl/core/fipa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fipa_pkg
// Shared constants and control/status types for the free ID pool allocator.
// ----------------------------------------------------------------------------
package fipa_pkg;

   localparam int MAX_IDS = 1024;
   localparam int ID_W    = $clog2(MAX_IDS);
   localparam int CNT_W   = ID_W + 1;
   localparam int FN_W    = 2;

   localparam logic [FN_W-1:0] FN_GET     = 2'd0;
   localparam logic [FN_W-1:0] FN_CHECK   = 2'd1;
   localparam logic [FN_W-1:0] FN_RELEASE = 2'd2;

   typedef struct packed {
      logic capture;     // latch transaction, issue memory reads
      logic execute;     // update pool state, load response register
      logic clear_step;  // clear one bitmap entry
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_last;  // clear pointer at last entry
      logic out_free;    // response register can take a new result
   } ctl_status_type;

endpackage

>>> rtl/core/fipa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fipa_ctrl
// Sequencer: bitmap clear pass, transaction capture, execute.
// ----------------------------------------------------------------------------
module fipa_ctrl
   import fipa_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_write_enable,
   input  logic           req_valid,
   output logic           req_stall,
   input  ctl_status_type status,
   output ctl_cmd_type    cmd
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in       = state_ff;
      cmd.capture    = 1'b0;
      cmd.execute    = 1'b0;
      cmd.clear_step = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.out_free) begin
               cmd.execute = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
      if (csr_write_enable) begin
         state_in = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (accept && !csr_write_enable) |=> (state_ff == ST_EXEC))
      else $error("accepted transaction did not reach execute");

   a_csr_restarts_clear: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> (state_ff == ST_CLEAR))
      else $error("pool_size write did not start clear pass");

   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.execute, cmd.clear_step}))
      else $error("conflicting datapath commands");
`endif

endmodule

>>> rtl/core/fipa_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fipa_dpath
// Taken bitmap, recycled stack, fresh/recycled counters, response register.
// ----------------------------------------------------------------------------
module fipa_dpath
   import fipa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  ctl_cmd_type      cmd,
   output ctl_status_type   status,
   input  logic             csr_write_enable,
   input  logic [CNT_W-1:0] csr_write_data,
   input  logic [FN_W-1:0]  req_func,
   input  logic [ID_W-1:0]  req_number,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [ID_W-1:0]  rsp_issued_number,
   output logic             rsp_success,
   output logic             rsp_out_of_range
);

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_IDS);
   localparam logic [ID_W-1:0]  LAST_ID = ID_W'(MAX_IDS - 1);

   logic             taken_mem [MAX_IDS];
   logic [ID_W-1:0]  stack_mem [MAX_IDS];

   logic [CNT_W-1:0] pool_size_ff, pool_size_in;
   logic [CNT_W-1:0] rec_cnt_ff, rec_cnt_in;
   logic [CNT_W-1:0] fresh_cnt_ff, fresh_cnt_in;
   logic [ID_W-1:0]  clr_ptr_ff, clr_ptr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]  rsp_num_ff, rsp_num_in;
   logic             rsp_ok_ff, rsp_ok_in;
   logic             rsp_oor_ff, rsp_oor_in;

   logic [FN_W-1:0]  func_ff;
   logic [ID_W-1:0]  num_ff;
   logic             rd_taken_ff;
   logic [ID_W-1:0]  rd_stack_ff;

   logic [CNT_W-1:0] rec_dec;
   logic [CNT_W-1:0] csr_size;
   logic             tk_we;
   logic [ID_W-1:0]  tk_addr;
   logic             tk_wdata;
   logic             st_we;
   logic [CNT_W-1:0] fresh_id;

   assign rec_dec  = rec_cnt_ff - CNT_W'(1);
   assign fresh_id = pool_size_ff - fresh_cnt_ff;
   assign csr_size = (csr_write_data > MAX_CNT) ? MAX_CNT : csr_write_data;

   assign status.clear_last = (clr_ptr_ff == LAST_ID);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      pool_size_in = pool_size_ff;
      rec_cnt_in   = rec_cnt_ff;
      fresh_cnt_in = fresh_cnt_ff;
      clr_ptr_in   = clr_ptr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_num_in   = rsp_num_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_oor_in   = rsp_oor_ff;
      tk_we        = 1'b0;
      tk_addr      = clr_ptr_ff;
      tk_wdata     = 1'b0;
      st_we        = 1'b0;

      if (cmd.clear_step) begin
         tk_we      = 1'b1;
         clr_ptr_in = clr_ptr_ff + ID_W'(1);
      end

      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
         rsp_num_in   = '0;
         rsp_ok_in    = 1'b0;
         rsp_oor_in   = 1'b0;
         case (func_ff)
            FN_GET: begin
               if (rec_cnt_ff != '0) begin
                  rec_cnt_in = rec_dec;
                  rsp_num_in = rd_stack_ff;
                  rsp_ok_in  = 1'b1;
                  tk_we      = 1'b1;
                  tk_addr    = rd_stack_ff;
                  tk_wdata   = 1'b1;
               end else if (fresh_cnt_ff != '0) begin
                  fresh_cnt_in = fresh_cnt_ff - CNT_W'(1);
                  rsp_num_in   = fresh_id[ID_W-1:0];
                  rsp_ok_in    = 1'b1;
                  tk_we        = 1'b1;
                  tk_addr      = fresh_id[ID_W-1:0];
                  tk_wdata     = 1'b1;
               end
            end
            FN_CHECK: begin
               if ({1'b0, num_ff} >= pool_size_ff) begin
                  rsp_oor_in = 1'b1;
               end else begin
                  rsp_ok_in = !rd_taken_ff;
               end
            end
            FN_RELEASE: begin
               if ({1'b0, num_ff} >= pool_size_ff) begin
                  rsp_oor_in = 1'b1;
               end else if (rd_taken_ff && (rec_cnt_ff < MAX_CNT)) begin
                  rec_cnt_in = rec_cnt_ff + CNT_W'(1);
                  rsp_ok_in  = 1'b1;
                  tk_we      = 1'b1;
                  tk_addr    = num_ff;
                  tk_wdata   = 1'b0;
                  st_we      = 1'b1;
               end
            end
            default: begin
               rsp_num_in = '0;
            end
         endcase
      end

      if (csr_write_enable) begin
         pool_size_in = csr_size;
         rec_cnt_in   = '0;
         fresh_cnt_in = csr_size;
         clr_ptr_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff <= MAX_CNT;
         rec_cnt_ff   <= '0;
         fresh_cnt_ff <= MAX_CNT;
         clr_ptr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pool_size_ff <= pool_size_in;
         rec_cnt_ff   <= rec_cnt_in;
         fresh_cnt_ff <= fresh_cnt_in;
         clr_ptr_ff   <= clr_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_num_ff <= rsp_num_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_oor_ff <= rsp_oor_in;
      if (cmd.capture) begin
         func_ff <= req_func;
         num_ff  <= req_number;
      end
   end

   // bitmap: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (tk_we) begin
         taken_mem[tk_addr] <= tk_wdata;
      end
      if (cmd.capture) begin
         rd_taken_ff <= taken_mem[req_number];
      end
   end

   // recycled stack: top entry read on capture
   always_ff @(posedge clock) begin
      if (st_we) begin
         stack_mem[rec_cnt_ff[ID_W-1:0]] <= num_ff;
      end
      if (cmd.capture) begin
         rd_stack_ff <= stack_mem[rec_dec[ID_W-1:0]];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_issued_number = rsp_num_ff;
   assign rsp_success       = rsp_ok_ff;
   assign rsp_out_of_range  = rsp_oor_ff;

`ifndef ASSERT_OFF
   a_free_count: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, rec_cnt_ff} + {1'b0, fresh_cnt_ff}) <= {1'b0, pool_size_ff})
      else $error("free identifier count exceeds pool size");

   a_pool_limit: assert property (@(posedge clock) disable iff (reset)
      pool_size_ff <= MAX_CNT)
      else $error("pool size above capacity");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |-> (!rsp_valid_ff || !rsp_stall))
      else $error("pending response overwritten");

   a_exec_result: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && !csr_write_enable) |=> rsp_valid_ff)
      else $error("executed transaction produced no response");
`endif

endmodule

>>> rtl/core/free_id_pool_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_id_pool_allocator
// Issues, checks and releases identifiers from a LIFO free pool.
// ----------------------------------------------------------------------------
// One transaction is processed at a time: the bitmap and stack reads are
// registered on acceptance, and the execute step then updates the pool and
// loads the response register once that register is free, so a new request
// is accepted only after the previous one has executed. A pending response
// does not block acceptance of the next request. After reset and after every
// pool_size write, a pass clears the taken bitmap, one entry per cycle, with
// req_stall held high.
module free_id_pool_allocator
   import fipa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [CNT_W-1:0] csr_write_data,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [FN_W-1:0]  req_func,
   input  logic [ID_W-1:0]  req_number,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [ID_W-1:0]  rsp_issued_number,
   output logic             rsp_success,
   output logic             rsp_out_of_range
);

   ctl_cmd_type    cmd;
   ctl_status_type status;

   fipa_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .status           (status),
      .cmd              (cmd)
   );

   fipa_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_func          (req_func),
      .req_number        (req_number),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_issued_number (rsp_issued_number),
      .rsp_success       (rsp_success),
      .rsp_out_of_range  (rsp_out_of_range)
   );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for free_id_pool_allocator. A scoreboard predicts each
// transaction from its own copy of the pool state: the taken bitmap, the
// recycled stack and the fresh counter. Directed transactions cover the
// corner cases. Random phases follow, each at a new pool size. Both sides
// idle at random, and the stimulus drains fully before every pool_size write.
// ----------------------------------------------------------------------------
module testbench;
   import fipa_pkg::*;

   localparam logic [FN_W-1:0] FN_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS = 200;
   localparam int PHASES = 8;

   typedef struct packed {
      logic [ID_W-1:0] issued;
      logic            success;
      logic            oor;
   } id_result_type;

   class id_pool_scoreboard_type;
      bit [CNT_W-1:0]  pool_size;
      bit              taken[MAX_IDS];
      bit [ID_W-1:0]   recycled[MAX_IDS];
      int unsigned     recycled_count;
      int unsigned     fresh_count;
      id_result_type   expected_q[$];
      int              errors;

      function new();
         errors = 0;
         set_pool(CNT_W'(MAX_IDS));
      endfunction

      function void set_pool(bit [CNT_W-1:0] v);
         pool_size = (v > MAX_IDS) ? CNT_W'(MAX_IDS) : v;
         foreach (taken[k]) taken[k] = 1'b0;
         recycled_count = 0;
         fresh_count = pool_size;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function int pick_taken();
         int start;
         int k;
         start = $urandom_range(MAX_IDS - 1);
         for (k = 0; k < MAX_IDS; k++)
            if (taken[(start + k) % MAX_IDS]) return (start + k) % MAX_IDS;
         return -1;
      endfunction

      function void note_request(logic [FN_W-1:0] f, logic [ID_W-1:0] n);
         id_result_type r;
         r = '0;
         if (f == FN_GET) begin
            if (recycled_count > 0) begin
               recycled_count--;
               r.issued = recycled[recycled_count];
               taken[r.issued] = 1'b1;
               r.success = 1'b1;
            end else if (fresh_count > 0) begin
               r.issued = ID_W'(pool_size - fresh_count);
               fresh_count--;
               taken[r.issued] = 1'b1;
               r.success = 1'b1;
            end
         end else if (f == FN_CHECK || f == FN_RELEASE) begin
            if (CNT_W'(n) >= pool_size) begin
               r.oor = 1'b1;
            end else if (f == FN_CHECK) begin
               r.success = !taken[n];
            end else if (taken[n]) begin
               taken[n] = 1'b0;
               recycled[recycled_count] = n;
               recycled_count++;
               r.success = 1'b1;
            end
         end
         expected_q.insert(expected_q.size(), r);
      endfunction

      function void check_result(id_result_type got);
         id_result_type exp;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected transaction issued=%0d success=%0d oor=%0d",
                     $time, got.issued, got.success, got.oor);
            errors++;
            return;
         end
         exp = expected_q.pop_front();
         if (got.issued !== exp.issued) begin
            $display("%0t: issued_number expected %0d actual %0d",
                     $time, exp.issued, got.issued);
            errors++;
         end
         if (got.success !== exp.success) begin
            $display("%0t: success expected %0d actual %0d", $time, exp.success, got.success);
            errors++;
         end
         if (got.oor !== exp.oor) begin
            $display("%0t: out_of_range expected %0d actual %0d", $time, exp.oor, got.oor);
            errors++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             csr_write_enable;
   logic [CNT_W-1:0] csr_write_data;
   logic             req_valid;
   logic             req_stall;
   logic [FN_W-1:0]  req_func;
   logic [ID_W-1:0]  req_number;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [ID_W-1:0]  rsp_issued_number;
   logic             rsp_success;
   logic             rsp_out_of_range;

   id_pool_scoreboard_type sb;
   bit                     steady;
   int                     idle_cycles;

   free_id_pool_allocator DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_number        (req_number),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_issued_number (rsp_issued_number),
      .rsp_success       (rsp_success),
      .rsp_out_of_range  (rsp_out_of_range)
   );

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_func = FN_GET;
      req_number = '0;
      rsp_stall = 1'b0;
      steady = 1'b0;
      idle_cycles = 0;
      sb = new();
   end

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 7);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result('{rsp_issued_number, rsp_success, rsp_out_of_range});
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_req(input logic [FN_W-1:0] f, input logic [ID_W-1:0] n);
      if (!steady && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_number <= n;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sb.note_request(f, n);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_pool(input logic [CNT_W-1:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_pool(v);
   endtask

   task automatic random_req(output logic [FN_W-1:0] f, output logic [ID_W-1:0] n);
      int roll;
      int id;
      int top;
      roll = $urandom_range(99);
      top = (sb.pool_size + 3 > MAX_IDS - 1) ? MAX_IDS - 1 : sb.pool_size + 3;
      n = ID_W'($urandom);
      if (roll < 40) begin
         f = FN_GET;
      end else if (roll < 75) begin
         f = FN_RELEASE;
         id = sb.pick_taken();
         if (id >= 0 && $urandom_range(3) != 0) n = ID_W'(id);
         else if ($urandom_range(1) == 0) n = ID_W'($urandom_range(top));
      end else if (roll < 95) begin
         f = FN_CHECK;
         id = sb.pick_taken();
         if (id >= 0 && $urandom_range(2) == 0) n = ID_W'(id);
         else if ($urandom_range(1) == 0) n = ID_W'($urandom_range(top));
      end else begin
         f = FN_UNUSED;
      end
   endtask

   initial begin
      int ph;
      int i;
      logic [FN_W-1:0]  f;
      logic [ID_W-1:0]  n;
      logic [CNT_W-1:0] size;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset pool size
      send_req(FN_GET, '0);
      send_req(FN_GET, '1);
      send_req(FN_CHECK, 10'd0);
      send_req(FN_CHECK, 10'd2);
      send_req(FN_RELEASE, 10'd0);
      send_req(FN_RELEASE, 10'd0);
      send_req(FN_GET, 10'd5);
      send_req(FN_RELEASE, 10'd1023);
      send_req(FN_CHECK, 10'd1023);
      send_req(FN_UNUSED, 10'd1023);
      drain();

      // single entry pool
      write_pool(11'd1);
      send_req(FN_GET, '0);
      send_req(FN_GET, '0);
      send_req(FN_CHECK, 10'd1);
      send_req(FN_RELEASE, 10'd1023);
      send_req(FN_RELEASE, 10'd0);
      send_req(FN_CHECK, 10'd0);
      send_req(FN_GET, '1);
      drain();

      // empty pool
      write_pool(11'd0);
      send_req(FN_GET, '0);
      send_req(FN_CHECK, 10'd0);
      send_req(FN_RELEASE, 10'd0);
      drain();

      // oversized write saturates
      write_pool(11'h7FF);
      send_req(FN_CHECK, 10'd1023);
      send_req(FN_GET, '0);

      for (ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph)
            0: size = CNT_W'(MAX_IDS);
            1: size = CNT_W'($urandom_range(MAX_IDS, 2047));
            default: size = CNT_W'($urandom_range(1, 48));
         endcase
         write_pool(size);
         steady = (ph == 3);
         for (i = 0; i < PHASE_ITEMS; i++) begin
            random_req(f, n);
            send_req(f, n);
         end
      end
      steady = 1'b0;

      drain();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> free_id_pool_allocator.f
rtl/core/fipa_pkg.sv
rtl/core/fipa_ctrl.sv
rtl/core/fipa_dpath.sv
rtl/core/free_id_pool_allocator.sv
verif/testbench.sv
